// ===== design/cbr_pkg.sv =====
package cbr_pkg;

	// drag handle codes
	localparam logic [3:0] H_TL     = 4'd0;
	localparam logic [3:0] H_TR     = 4'd1;
	localparam logic [3:0] H_BL     = 4'd2;
	localparam logic [3:0] H_BR     = 4'd3;
	localparam logic [3:0] H_TOP    = 4'd4;
	localparam logic [3:0] H_BOTTOM = 4'd5;
	localparam logic [3:0] H_LEFT   = 4'd6;
	localparam logic [3:0] H_RIGHT  = 4'd7;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SAT   = 2'd1;
	localparam logic [1:0] ST_ZEROW = 2'd2;

	// constraint mode value with no constraint
	localparam logic [1:0] MODE_FREE = 2'd0;

	// constraint mode bits
	localparam int MODE_PROP   = 0;
	localparam int MODE_CENTER = 1;

endpackage

// ===== design/constrained_box_resize_core.sv =====
// throughput: one beat per cycle; the proportional height goes through a restoring divider
// that retires one quotient bit per pipeline stage, one stage per bit of the 2*COORD_WIDTH
// product; a held result stalls the whole pipeline, a free output slot lets bubbles advance
// reset: arst_n clears all valid bits and sets constraint_mode to free
module constrained_box_resize_core
	import cbr_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [3:0]                    handle_code,
	input  logic signed [COORD_WIDTH-1:0] delta_horiz,
	input  logic signed [COORD_WIDTH-1:0] delta_vert,
	input  logic signed [COORD_WIDTH-1:0] orig_left,
	input  logic signed [COORD_WIDTH-1:0] orig_top,
	input  logic signed [COORD_WIDTH-1:0] orig_width,
	input  logic signed [COORD_WIDTH-1:0] orig_height,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] new_left,
	output logic signed [COORD_WIDTH-1:0] new_top,
	output logic signed [COORD_WIDTH-1:0] new_width,
	output logic signed [COORD_WIDTH-1:0] new_height,
	output logic [1:0]                    status
);

	localparam int CW = COORD_WIDTH;
	localparam int ND = 2 * CW;
	localparam int XW = CW + 3;

	typedef struct packed {
		logic signed [CW-1:0] l;
		logic signed [CW-1:0] t;
		logic signed [CW-1:0] w;
		logic signed [CW-1:0] h;
		logic signed [CW-1:0] ol;
		logic signed [CW-1:0] ot;
		logic signed [CW-1:0] ow;
		logic signed [CW-1:0] oh;
		logic                 satf;
	} box_t;

	typedef struct packed {
		logic          neg;
		logic          prop;
		logic          zerow;
		logic [CW-1:0] dmag;
		logic [CW-1:0] rem;
		logic [ND-1:0] num;
	} div_t;

	localparam logic signed [XW-1:0] CMAX_X = XW'(signed'({1'b0, {(CW-1){1'b1}}}));
	localparam logic signed [XW-1:0] CMIN_X = -CMAX_X - XW'(1);

	// saturate a wide signed value to CW bits; msb of result is the saturation flag
	function automatic logic [CW:0] sat_x(input logic signed [XW-1:0] x);
		logic [CW:0] r;
		if (x > CMAX_X) begin
			r = {1'b1, CMAX_X[CW-1:0]};
		end else if (x < CMIN_X) begin
			r = {1'b1, CMIN_X[CW-1:0]};
		end else begin
			r = {1'b0, x[CW-1:0]};
		end
		return r;
	endfunction

	function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] x);
		return x[CW-1] ? CW'(-x) : CW'(x);
	endfunction

	logic [1:0] mode_q;
	logic       en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FREE;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: edge moves
	logic mv_l, mv_r, mv_t, mv_b;
	logic [CW:0] sl, sw, st, sh;
	box_t e_d;
	box_t e_s1;
	logic v_s1;

	always_comb begin
		mv_l = (handle_code == H_TL) || (handle_code == H_BL) || (handle_code == H_LEFT);
		mv_r = (handle_code == H_TR) || (handle_code == H_BR) || (handle_code == H_RIGHT);
		mv_t = (handle_code == H_TL) || (handle_code == H_TR) || (handle_code == H_TOP);
		mv_b = (handle_code == H_BL) || (handle_code == H_BR) || (handle_code == H_BOTTOM);
		sl = sat_x(XW'(orig_left) + XW'(delta_horiz));
		st = sat_x(XW'(orig_top) + XW'(delta_vert));
		sw = mv_l ? sat_x(XW'(orig_width) - XW'(delta_horiz))
		          : sat_x(XW'(orig_width) + XW'(delta_horiz));
		sh = mv_t ? sat_x(XW'(orig_height) - XW'(delta_vert))
		          : sat_x(XW'(orig_height) + XW'(delta_vert));
		e_d.ol   = orig_left;
		e_d.ot   = orig_top;
		e_d.ow   = orig_width;
		e_d.oh   = orig_height;
		e_d.l    = mv_l ? sl[CW-1:0] : orig_left;
		e_d.t    = mv_t ? st[CW-1:0] : orig_top;
		e_d.w    = (mv_l || mv_r) ? sw[CW-1:0] : orig_width;
		e_d.h    = (mv_t || mv_b) ? sh[CW-1:0] : orig_height;
		e_d.satf = (mv_l && (sl[CW] || sw[CW])) || (mv_r && sw[CW])
		        || (mv_t && (st[CW] || sh[CW])) || (mv_b && sh[CW]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1 <= e_d;
		end
	end

	// stage 2: magnitude product and divider setup
	box_t m_s2;
	div_t md_s2;
	logic v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2        <= e_s1;
			md_s2.neg   <= e_s1.w[CW-1] ^ e_s1.oh[CW-1] ^ e_s1.ow[CW-1];
			md_s2.prop  <= mode_q[MODE_PROP] && (e_s1.oh > 0);
			md_s2.zerow <= mode_q[MODE_PROP] && (e_s1.oh > 0) && (e_s1.ow == '0);
			md_s2.dmag  <= mag(e_s1.ow);
			md_s2.rem   <= '0;
			md_s2.num   <= ND'(mag(e_s1.w)) * ND'(mag(e_s1.oh));
		end
	end

	// divider: one quotient bit per stage
	box_t dvb_s [ND+1];
	div_t dv_s [ND+1];
	logic dv_v_s [ND+1];

	assign dvb_s[0]  = m_s2;
	assign dv_s[0]   = md_s2;
	assign dv_v_s[0] = v_s2;

	for (genvar i = 0; i < ND; i++) begin : g_div
		logic [CW:0] rs;
		logic        ge;
		div_t        nx;

		always_comb begin
			rs = {dv_s[i].rem, dv_s[i].num[ND-1]};
			ge = rs >= {1'b0, dv_s[i].dmag};
			nx = dv_s[i];
			nx.rem = ge ? CW'(rs - {1'b0, dv_s[i].dmag}) : rs[CW-1:0];
			nx.num = {dv_s[i].num[ND-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[i+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[i+1] <= dv_v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvb_s[i+1] <= dvb_s[i];
				dv_s[i+1]  <= nx;
			end
		end
	end

	// height stage: sign and saturate the quotient
	localparam logic [ND-1:0] LIM_POS = ND'({1'b0, {(CW-1){1'b1}}});
	localparam logic [ND-1:0] LIM_NEG = LIM_POS + ND'(1);

	box_t h_s3;
	logic v_s3;
	logic zw_s3;
	logic over;
	logic [CW-1:0] hq;
	div_t dl;
	box_t hb;

	always_comb begin
		dl   = dv_s[ND];
		over = dl.num > (dl.neg ? LIM_NEG : LIM_POS);
		if (over) begin
			hq = dl.neg ? CMIN_X[CW-1:0] : CMAX_X[CW-1:0];
		end else begin
			hq = dl.neg ? CW'(-dl.num[CW-1:0]) : dl.num[CW-1:0];
		end
		hb = dvb_s[ND];
		if (dl.prop && !dl.zerow) begin
			hb.h    = hq;
			hb.satf = dvb_s[ND].satf || over;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= dv_v_s[ND];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s3  <= hb;
			zw_s3 <= dl.zerow;
		end
	end

	// output stage: center anchoring
	logic [CW:0] cl, ct;
	logic signed [XW-1:0] sum_l, sum_t;

	always_comb begin
		sum_l = (XW'(h_s3.ol) <<< 1) + XW'(h_s3.ow) - XW'(h_s3.w);
		sum_t = (XW'(h_s3.ot) <<< 1) + XW'(h_s3.oh) - XW'(h_s3.h);
		cl = sat_x(sum_l >>> 1);
		ct = sat_x(sum_t >>> 1);
	end

	logic v_s4;
	logic signed [CW-1:0] l_s4, t_s4, w_s4, h_s4;
	logic [1:0] st_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s4 <= h_s3.w;
			h_s4 <= h_s3.h;
			if (mode_q[MODE_CENTER]) begin
				l_s4 <= cl[CW-1:0];
				t_s4 <= ct[CW-1:0];
			end else begin
				l_s4 <= h_s3.l;
				t_s4 <= h_s3.t;
			end
			if (zw_s3) begin
				st_s4 <= ST_ZEROW;
			end else if (h_s3.satf || (mode_q[MODE_CENTER] && (cl[CW] || ct[CW]))) begin
				st_s4 <= ST_SAT;
			end else begin
				st_s4 <= ST_OK;
			end
		end
	end

	assign out_valid  = v_s4;
	assign new_left   = l_s4;
	assign new_top    = t_s4;
	assign new_width  = w_s4;
	assign new_height = h_s4;
	assign status     = st_s4;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_SAT || status == ST_ZEROW))
		else $error("status code out of range");

	a_zerow_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ZEROW |-> mode_q[MODE_PROP])
		else $error("zero width status outside proportional mode");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s3) && $stable(dv_v_s[ND]) && $stable(v_s1))
		else $error("pipeline moved during a stall");

	a_zerow_height: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && zw_s3 && en |=> h_s4 == $past(h_s3.h))
		else $error("height changed with zero original width");

endmodule
